// File: design/ict_pkg.sv
// Shared types, codes and field widths for the inode cache table.
package ict_pkg;

  localparam int NUM_W        = 16;
  localparam int SLOT_W       = 4;
  localparam int CNT_W        = 8;
  localparam int LINK_W       = 8;
  localparam int SECT_W       = 17;
  localparam int STAT_W       = 4;
  localparam int MODE_W       = 2;
  localparam int ZONE_W       = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int SYNC_N_W     = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_GET  = 2'd0,
    MODE_PUT  = 2'd1,
    MODE_SYNC = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT     = 4'd0,
    ST_LOADED  = 4'd1,
    ST_FULL    = 4'd2,
    ST_STILL   = 4'd3,
    ST_RELEASE = 4'd4,
    ST_FREED   = 4'd5,
    ST_WBACK   = 4'd6,
    ST_PERR    = 4'd7,
    ST_SNONE   = 4'd8
  } status_t;

  // Kind of result the controller asks the datapath to build.
  typedef enum logic [2:0] {
    K_HIT  = 3'd0,
    K_MISS = 3'd1,
    K_PUT  = 3'd2,
    K_SYNC = 3'd3,
    K_NONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic  capture;
    logic  rd;
    logic  hold;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic any_used;
    logic pv;
    logic used_p;
    logic hit_p;
    logic last_p;
    logic idx_end;
    logic more_above;
    logic sync_cap;
    logic out_free;
  } sts_t;

endpackage

// File: design/ict_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ict_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/ict_ctrl.sv
// Controller state machine: sequences get, put and sync walks over the table.
module ict_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ict_pkg::MODE_W-1:0]    in_mode,
  output logic                          in_ready,
  input  ict_pkg::sts_t                 sts,
  output ict_pkg::cmd_t                 cmd
);
  import ict_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GET  = 5'b00010,
    S_PUT  = 5'b00100,
    S_SYNC = 5'b01000,
    S_NONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   sync_done;

  assign sync_done = !sts.more_above || sts.sync_cap;

  always_comb begin
    cmd       = '0;
    cmd.kind  = K_NONE;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (in_mode == MODE_GET) begin
            cmd.rd    = 1'b1;
            state_nxt = S_GET;
          end else if (in_mode == MODE_PUT) begin
            cmd.rd    = 1'b1;
            state_nxt = S_PUT;
          end else if (in_mode == MODE_SYNC) begin
            if (sts.any_used) begin
              cmd.rd    = 1'b1;
              state_nxt = S_SYNC;
            end else begin
              state_nxt = S_NONE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_GET: begin
        if (sts.hit_p || sts.last_p) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = sts.hit_p ? K_HIT : K_MISS;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.hold = 1'b1;
          end
        end else if (sts.pv && !sts.idx_end) begin
          cmd.rd = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = K_PUT;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.hold = 1'b1;
        end
      end
      S_SYNC: begin
        if (sts.used_p) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.kind = K_SYNC;
            cmd.last = sync_done;
            if (sync_done) begin
              state_nxt = S_IDLE;
            end else if (!sts.idx_end) begin
              cmd.rd = 1'b1;
            end
          end else begin
            cmd.hold = 1'b1;
          end
        end else if (sts.pv && !sts.idx_end) begin
          cmd.rd = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = K_NONE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd && state_r != S_IDLE) |-> !sts.idx_end)
    else $error("table read issued past the last entry");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("final result of a transaction did not return to idle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted into an occupied output register");

endmodule

// File: design/ict_dp.sv
// Datapath: table RAM, in-use bits, walk counters, sector math and result register.
module ict_dp #(
  parameter int ENTRIES           = 16,
  parameter int INODES_PER_SECTOR = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ict_pkg::cmd_t                 cmd,
  output ict_pkg::sts_t                 sts,
  input  logic [ict_pkg::MODE_W-1:0]    in_mode,
  input  logic [ict_pkg::NUM_W-1:0]     in_inode_number,
  input  logic [ict_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ict_pkg::LINK_W-1:0]    in_link_count,
  input  logic [ict_pkg::ZONE_W-1:0]    zone_start,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ict_pkg::STAT_W-1:0]    out_status,
  output logic [ict_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [ict_pkg::NUM_W-1:0]     out_inode_out,
  output logic [ict_pkg::SECT_W-1:0]    out_load_sector,
  output logic [ict_pkg::CNT_W-1:0]     out_count_out,
  output logic                          out_last
);
  import ict_pkg::*;

  localparam int IW    = $clog2(ENTRIES);
  localparam int DIV   = (INODES_PER_SECTOR < 1) ? 1 : INODES_PER_SECTOR;
  localparam int LG    = $clog2(DIV);
  localparam int SH    = NUM_W + LG;
  localparam int RECIP = (1 << SH) / DIV + 1;
  localparam int RW    = NUM_W + 1;
  localparam int PW    = NUM_W + RW + LG;
  localparam int RAM_W = CNT_W + NUM_W;

  logic [NUM_W-1:0]    num_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [LINK_W-1:0]   link_r;
  logic [IW:0]         idx_r;
  logic [IW-1:0]       pidx_r;
  logic                pv_r;
  logic [ENTRIES-1:0]  used_r;
  logic                free_found_r;
  logic [IW-1:0]       free_idx_r;
  logic [SYNC_N_W-1:0] sync_n_r;
  logic [NUM_W-1:0]    quot_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [NUM_W-1:0]    out_inode_r;
  logic [SECT_W-1:0]   out_sector_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_last_r;

  logic [IW+SLOT_W-1:0] slot_ext;
  logic [IW-1:0]        slot_addr;
  logic [IW-1:0]        rd_addr;
  logic [RAM_W-1:0]     ram_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [NUM_W-1:0]     ent_q;
  logic                 used_raw;
  logic                 used_p;
  logic                 slot_oob;
  logic [ENTRIES-1:0]   above;
  logic                 free_any;
  logic [IW-1:0]        fidx;
  logic [SLOT_W+IW-1:0] pidx_ext;
  logic [SLOT_W+IW-1:0] fidx_ext;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     cnt_dec;
  logic [PW-1:0]        prod;
  logic [SECT_W-1:0]    sector;
  logic                 out_free;

  logic                 we;
  logic [IW-1:0]        waddr;
  logic [RAM_W-1:0]     wdata;
  logic                 used_set;
  logic                 used_clr;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [NUM_W-1:0]     res_inode;
  logic [SECT_W-1:0]    res_sector;
  logic [CNT_W-1:0]     res_count;

  assign slot_ext  = {{IW{1'b0}}, in_slot};
  assign slot_addr = slot_ext[IW-1:0];
  assign rd_addr   = cmd.capture ? ((in_mode == MODE_PUT) ? slot_addr : '0) : idx_r[IW-1:0];

  assign {cnt_q, ent_q} = ram_q;
  assign used_raw = used_r[pidx_r];
  assign used_p   = pv_r && used_raw;
  assign slot_oob = {{IW{1'b0}}, slot_r} >= (IW+SLOT_W)'(ENTRIES);

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      above[j] = used_r[j] && ((IW+1)'(j) > {1'b0, pidx_r});
    end
  end

  // The slot under compare counts as free too when the walk reaches the end.
  assign free_any = free_found_r || !used_raw;
  assign fidx     = free_found_r ? free_idx_r : pidx_r;
  assign pidx_ext = {{SLOT_W{1'b0}}, pidx_r};
  assign fidx_ext = {{SLOT_W{1'b0}}, fidx};

  assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);

  // Divide by the sectors' inode count with a reciprocal multiply.
  assign prod   = PW'(num_r) * PW'(RECIP);
  assign sector = {1'b0, zone_start} + {1'b0, quot_r};

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts            = '0;
    sts.any_used   = |used_r;
    sts.pv         = pv_r;
    sts.used_p     = used_p;
    sts.hit_p      = used_p && (ent_q == num_r);
    sts.last_p     = pv_r && (pidx_r == IW'(ENTRIES - 1));
    sts.idx_end    = (idx_r == (IW+1)'(ENTRIES));
    sts.more_above = |above;
    sts.sync_cap   = (sync_n_r == SYNC_N_W'(RESULT_LIMIT - 1));
    sts.out_free   = out_free;
  end

  always_comb begin
    we         = 1'b0;
    waddr      = pidx_r;
    wdata      = '0;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    res_status = ST_SNONE;
    res_slot   = '0;
    res_inode  = '0;
    res_sector = '0;
    res_count  = '0;
    if (cmd.emit) begin
      unique case (cmd.kind)
        K_HIT: begin
          res_status = ST_HIT;
          res_slot   = pidx_ext[SLOT_W-1:0];
          res_inode  = num_r;
          res_count  = cnt_inc;
          we         = 1'b1;
          wdata      = {cnt_inc, num_r};
        end
        K_MISS: begin
          if (free_any) begin
            res_status = ST_LOADED;
            res_slot   = fidx_ext[SLOT_W-1:0];
            res_inode  = num_r;
            res_sector = sector;
            res_count  = CNT_W'(1);
            we         = 1'b1;
            waddr      = fidx;
            wdata      = {CNT_W'(1), num_r};
            used_set   = 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
        K_PUT: begin
          if (slot_oob) begin
            res_status = ST_PERR;
          end else if (!used_raw) begin
            res_status = ST_PERR;
            res_slot   = slot_r;
          end else if (cnt_q == CNT_W'(1)) begin
            res_status = (link_r == '0) ? ST_FREED : ST_RELEASE;
            res_slot   = slot_r;
            res_inode  = ent_q;
            used_clr   = 1'b1;
          end else begin
            res_status = ST_STILL;
            res_slot   = slot_r;
            res_inode  = ent_q;
            res_count  = cnt_dec;
            we         = 1'b1;
            wdata      = {cnt_dec, ent_q};
          end
        end
        K_SYNC: begin
          res_status = ST_WBACK;
          res_slot   = pidx_ext[SLOT_W-1:0];
          res_inode  = ent_q;
          res_count  = cnt_q;
        end
        K_NONE: begin
          res_status = ST_SNONE;
        end
        default: begin
          res_status = ST_SNONE;
        end
      endcase
    end
  end

  ict_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r         <= 1'b0;
      used_r       <= '0;
      free_found_r <= 1'b0;
      sync_n_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.rd) begin
        pv_r <= 1'b1;
      end else if (!cmd.hold) begin
        pv_r <= 1'b0;
      end
      if (used_set) begin
        used_r[fidx] <= 1'b1;
      end
      if (used_clr) begin
        used_r[pidx_r] <= 1'b0;
      end
      if (cmd.capture) begin
        free_found_r <= 1'b0;
      end else if (pv_r && !used_raw) begin
        free_found_r <= 1'b1;
      end
      if (cmd.capture) begin
        sync_n_r <= '0;
      end else if (cmd.emit && cmd.kind == K_SYNC) begin
        sync_n_r <= sync_n_r + SYNC_N_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= prod[SH +: NUM_W];
    if (cmd.capture) begin
      num_r  <= in_inode_number;
      slot_r <= in_slot;
      link_r <= in_link_count;
      idx_r  <= (IW+1)'(1);
    end else if (cmd.rd) begin
      idx_r <= idx_r + (IW+1)'(1);
    end
    if (cmd.rd) begin
      pidx_r <= rd_addr;
    end
    if (pv_r && !used_raw && !free_found_r && !cmd.capture) begin
      free_idx_r <= pidx_r;
    end
    if (cmd.emit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_inode_r  <= res_inode;
      out_sector_r <= res_sector;
      out_count_r  <= res_count;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_out    = out_slot_r;
  assign out_inode_out   = out_inode_r;
  assign out_load_sector = out_sector_r;
  assign out_count_out   = out_count_r;
  assign out_last        = out_last_r;

  a_load_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.kind == K_MISS && free_any) |=> used_r[$past(fidx)])
    else $error("loaded slot not marked in use");

  a_perr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_PERR) |-> (out_count_r == '0 && out_inode_r == '0))
    else $error("put error carries a nonzero inode or count");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    used_clr |=> !used_r[$past(pidx_r)])
    else $error("released slot still marked in use");

endmodule

// File: design/inode_cache_table_unit.sv
// Top level of the inode cache table: configuration register, controller and datapath.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    mode, inode_number, slot, link_count
//  out_     output     out_valid / out_ready  status, slot_out, inode_out, load_sector,
//                                             count_out, last
//  APB      config     psel/penable/pwrite    zone_start_sector at byte address 0
//
//  Get: after capture, one table entry is compared per cycle, up to ENTRIES
//  entries; the walk stops early on a hit. Put: one read of the named slot. Sync:
//  after capture, one entry per cycle up to the highest slot in use (at most ENTRIES),
//  while the output register is free; a none result when nothing is referenced.
//  A result that waits on out_ready holds the walk. The table RAM is single-read.
//  Reset is synchronous and clears the in-use bits at once; no clearing pass runs.
//  A full output register holds the walk at the entry that must report; the next
//  transaction is taken once the controller is back in idle, even while the last
//  result still waits.
module inode_cache_table_unit #(
  parameter int ENTRIES           = 16,
  parameter int INODES_PER_SECTOR = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ict_pkg::MODE_W-1:0]    in_mode,
  input  logic [ict_pkg::NUM_W-1:0]     in_inode_number,
  input  logic [ict_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ict_pkg::LINK_W-1:0]    in_link_count,
  // result transaction
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ict_pkg::STAT_W-1:0]    out_status,
  output logic [ict_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [ict_pkg::NUM_W-1:0]     out_inode_out,
  output logic [ict_pkg::SECT_W-1:0]    out_load_sector,
  output logic [ict_pkg::CNT_W-1:0]     out_count_out,
  output logic                          out_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ict_pkg::*;

  logic [ZONE_W-1:0] zone_r;
  logic              cfg_wr;
  logic              zone_sel;
  cmd_t              cmd;
  sts_t              sts;

  // Register 0 sits at byte 0; byte 4 is outside the map and ignored.
  assign zone_sel = (paddr[2] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = zone_sel ? {{(32-ZONE_W){1'b0}}, zone_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_wr && zone_sel) begin
      zone_r <= pwdata[ZONE_W-1:0];
    end
  end

  // Controller: decides when to read, compare, stall and emit.
  ict_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the table and builds every result.
  ict_dp #(
    .ENTRIES           (ENTRIES),
    .INODES_PER_SECTOR (INODES_PER_SECTOR)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_inode_number (in_inode_number),
    .in_slot         (in_slot),
    .in_link_count   (in_link_count),
    .zone_start      (zone_r),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_inode_out   (out_inode_out),
    .out_load_sector (out_load_sector),
    .out_count_out   (out_count_out),
    .out_last        (out_last)
  );

endmodule

// File: sim/ict_outcome_checker.sv
// Checker for the inode cache table: predicts result transactions and compares them.
`timescale 1ns / 100ps

module ict_outcome_checker #(
  parameter int          ENTRIES           = 16,
  parameter int          INODES_PER_SECTOR = 8,
  parameter logic [2:0]  ZONE_ADDR         = 3'd0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ict_pkg::MODE_W-1:0]  in_mode,
  input  logic [ict_pkg::NUM_W-1:0]   in_inode_number,
  input  logic [ict_pkg::SLOT_W-1:0]  in_slot,
  input  logic [ict_pkg::LINK_W-1:0]  in_link_count,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [ict_pkg::STAT_W-1:0]  out_status,
  input  logic [ict_pkg::SLOT_W-1:0]  out_slot_out,
  input  logic [ict_pkg::NUM_W-1:0]   out_inode_out,
  input  logic [ict_pkg::SECT_W-1:0]  out_load_sector,
  input  logic [ict_pkg::CNT_W-1:0]   out_count_out,
  input  logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output int                          mismatch_total,
  output int                          results_owed
);
  import ict_pkg::*;

  localparam int SECTOR_DIV = (INODES_PER_SECTOR == 0) ? 1 : INODES_PER_SECTOR;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [NUM_W-1:0]  inode;
    logic [SECT_W-1:0] sector;
    logic [CNT_W-1:0]  count;
    logic              last;
  } outcome_t;

  logic [NUM_W-1:0]  held_num [ENTRIES];
  logic [CNT_W-1:0]  use_cnt  [ENTRIES];
  logic [ZONE_W-1:0] zone_start;
  outcome_t          awaited_results [$];
  outcome_t          want;

  function automatic void owe(status_t st, int sl, logic [NUM_W-1:0] ino,
                              logic [SECT_W-1:0] sec, logic [CNT_W-1:0] cnt, logic lst);
    outcome_t o;
    o.status = st;
    o.slot   = SLOT_W'(sl);
    o.inode  = ino;
    o.sector = sec;
    o.count  = cnt;
    o.last   = lst;
    awaited_results.push_back(o);
  endfunction

  // Update the table shadow for one accepted request and queue its results.
  function automatic void apply_request(logic [MODE_W-1:0] mode, logic [NUM_W-1:0] num,
                                        logic [SLOT_W-1:0] slot, logic [LINK_W-1:0] links);
    int found;
    int in_use;
    int total;
    int reported;
    logic [NUM_W-1:0]  held;
    logic [SECT_W-1:0] sector;
    found    = -1;
    in_use   = 0;
    reported = 0;
    case (mode)
      MODE_GET: begin
        for (int i = 0; i < ENTRIES; i++)
          if (found < 0 && use_cnt[i] != 0 && held_num[i] == num) found = i;
        if (found >= 0) begin
          if (use_cnt[found] != '1) use_cnt[found]++;
          owe(ST_HIT, found, num, '0, use_cnt[found], 1'b1);
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && use_cnt[i] == 0) found = i;
          if (found >= 0) begin
            sector = SECT_W'(zone_start) + SECT_W'(32'(num) / SECTOR_DIV);
            held_num[found] = num;
            use_cnt[found]  = 1;
            owe(ST_LOADED, found, num, sector, 8'd1, 1'b1);
          end else begin
            owe(ST_FULL, 0, '0, '0, '0, 1'b1);
          end
        end
      end
      MODE_PUT: begin
        if (slot >= ENTRIES) begin
          owe(ST_PERR, 0, '0, '0, '0, 1'b1);
        end else if (use_cnt[slot] == 0) begin
          owe(ST_PERR, slot, '0, '0, '0, 1'b1);
        end else if (use_cnt[slot] == 1) begin
          held           = held_num[slot];
          use_cnt[slot]  = 0;
          held_num[slot] = '0;
          owe((links == 0) ? ST_FREED : ST_RELEASE, slot, held, '0, '0, 1'b1);
        end else begin
          use_cnt[slot]--;
          owe(ST_STILL, slot, held_num[slot], '0, use_cnt[slot], 1'b1);
        end
      end
      MODE_SYNC: begin
        for (int i = 0; i < ENTRIES; i++)
          if (use_cnt[i] != 0) in_use++;
        total = (in_use > RESULT_LIMIT) ? RESULT_LIMIT : in_use;
        for (int i = 0; i < ENTRIES && reported < total; i++) begin
          if (use_cnt[i] != 0) begin
            owe(ST_WBACK, i, held_num[i], '0, use_cnt[i], reported == total - 1);
            reported++;
          end
        end
        if (total == 0) owe(ST_SNONE, 0, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void field_check(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        held_num[i] = '0;
        use_cnt[i]  = '0;
      end
      zone_start = '0;
      awaited_results.delete();
      mismatch_total = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expectation: status %0d slot %0d",
                 out_status, out_slot_out);
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          field_check("status", 32'(want.status), 32'(out_status));
          field_check("slot_out", 32'(want.slot), 32'(out_slot_out));
          field_check("inode_out", 32'(want.inode), 32'(out_inode_out));
          field_check("load_sector", 32'(want.sector), 32'(out_load_sector));
          field_check("count_out", 32'(want.count), 32'(out_count_out));
          field_check("last", 32'(want.last), 32'(out_last));
        end
      end
      if (psel && penable && pwrite && pready && paddr == ZONE_ADDR)
        zone_start = pwdata[ZONE_W-1:0];
      if (in_valid && in_ready)
        apply_request(in_mode, in_inode_number, in_slot, in_link_count);
    end
    results_owed = awaited_results.size();
  end

endmodule

// File: sim/inode_cache_table_unit_tb.sv
// Testbench top for the inode cache table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module inode_cache_table_unit_tb;
  import ict_pkg::*;

  localparam int               ENTRIES           = 16;
  localparam int               INODES_PER_SECTOR = 8;
  localparam logic [2:0]       ZONE_REG_ADDR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;
  // Margin for the walk of a request that gives no result to run out.
  localparam int               DRAIN_WAIT        = 40;
  localparam int               HOLD_OFF          = 300;
  localparam int               POOL_SIZE         = 24;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [MODE_W-1:0]  in_mode;
  logic [NUM_W-1:0]   in_inode_number;
  logic [SLOT_W-1:0]  in_slot;
  logic [LINK_W-1:0]  in_link_count;
  logic               out_valid;
  logic               out_ready;
  logic [STAT_W-1:0]  out_status;
  logic [SLOT_W-1:0]  out_slot_out;
  logic [NUM_W-1:0]   out_inode_out;
  logic [SECT_W-1:0]  out_load_sector;
  logic [CNT_W-1:0]   out_count_out;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int                 mismatch_total;
  int                 results_owed;

  // Set by the stimulus to request one long receiver stall; cleared by the receiver.
  bit                 long_hold = 1'b0;
  // Set near the end of the run: no more idling on either side.
  bit                 calm      = 1'b0;

  logic [NUM_W-1:0]   num_pool [POOL_SIZE];

  // 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  inode_cache_table_unit #(
    .ENTRIES           (ENTRIES),
    .INODES_PER_SECTOR (INODES_PER_SECTOR)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_inode_number (in_inode_number),
    .in_slot         (in_slot),
    .in_link_count   (in_link_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_inode_out   (out_inode_out),
    .out_load_sector (out_load_sector),
    .out_count_out   (out_count_out),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  ict_outcome_checker #(
    .ENTRIES           (ENTRIES),
    .INODES_PER_SECTOR (INODES_PER_SECTOR),
    .ZONE_ADDR         (ZONE_REG_ADDR)
  ) i_outcome_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_inode_number (in_inode_number),
    .in_slot         (in_slot),
    .in_link_count   (in_link_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_inode_out   (out_inode_out),
    .out_load_sector (out_load_sector),
    .out_count_out   (out_count_out),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_total  (mismatch_total),
    .results_owed    (results_owed)
  );

  // Offer one request transaction. Enter and leave on a falling edge; valid stays
  // high on return so a following request goes out back to back.
  task automatic offer(logic [MODE_W-1:0] mode, logic [NUM_W-1:0] num,
                       logic [SLOT_W-1:0] slot, logic [LINK_W-1:0] links);
    // Drop valid for a random burst now and then.
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_inode_number <= num;
    in_slot         <= slot;
    in_link_count   <= links;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come, then let the
  // walk of any request that causes no result run out.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Write the inode zone start over the register port: setup, then access.
  task automatic zone_write(logic [ZONE_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ZONE_REG_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int                counted;
    int                pick;
    logic [MODE_W-1:0] mode;
    logic [NUM_W-1:0]  num;
    logic [SLOT_W-1:0] slot;
    logic [LINK_W-1:0] links;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_GET;
    in_inode_number = '0;
    in_slot         = '0;
    in_link_count   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    // Small pool of inode numbers so random gets hit often; keep the extremes in it.
    num_pool[0] = '0;
    num_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) num_pool[i] = NUM_W'($urandom_range(0, 65535));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, highest zone start so the sector sum uses the top bit.
    zone_write('1);
    offer(MODE_SYNC, 16'h0000, 4'd0, 8'd0);      // nothing referenced
    offer(MODE_PUT, 16'h0000, 4'd0, 8'd0);       // put on a free slot
    offer(MODE_PUT, 16'hFFFF, 4'd15, 8'hFF);     // put on the last slot, free
    offer(MODE_GET, 16'h0000, 4'd0, 8'd0);       // load into slot 0
    offer(MODE_GET, 16'hFFFF, 4'd15, 8'hFF);     // load, largest sector
    offer(MODE_GET, 16'h0000, 4'd0, 8'd0);       // hit
    offer(MODE_GET, 16'hFFFF, 4'd0, 8'd0);       // hit
    offer(MODE_UNUSED, 16'hFFFF, 4'd15, 8'hFF);  // ignored, no result
    offer(MODE_SYNC, 16'h0000, 4'd0, 8'd0);      // two write-backs
    offer(MODE_PUT, 16'h0000, 4'd0, 8'd3);       // still referenced
    offer(MODE_PUT, 16'h0000, 4'd0, 8'd0);       // released and freed
    offer(MODE_PUT, 16'h0000, 4'd0, 8'd0);       // put error, slot now free
    offer(MODE_PUT, 16'h0000, 4'd1, 8'hFF);      // still referenced
    offer(MODE_PUT, 16'h0000, 4'd1, 8'd1);       // released, links kept
    offer(MODE_GET, 16'h5555, 4'd5, 8'h55);
    offer(MODE_GET, 16'hAAAA, 4'd10, 8'hAA);
    offer(MODE_PUT, 16'h0000, 4'd1, 8'h80);
    offer(MODE_GET, 16'h0001, 4'd0, 8'd0);       // reclaims the lowest free slot
    quiesce();

    // Saturate slot 0: hits past the count limit must leave it at the top.
    zone_write('0);
    repeat (260)
      offer(MODE_GET, 16'h5555, SLOT_W'($urandom_range(0, 15)),
            LINK_W'($urandom_range(0, 255)));
    offer(MODE_PUT, 16'h0000, 4'd0, 8'd7);

    // Fill the table while the receiver holds off, so the block backs up; then
    // run into a full table and sync every slot.
    long_hold = 1'b1;
    for (int i = 0; i < ENTRIES; i++)
      offer(MODE_GET, NUM_W'(16'h1000 + i), 4'd0, 8'd0);
    offer(MODE_SYNC, 16'h0000, 4'd0, 8'd0);
    quiesce();

    // Random part: three settings of the zone start, mostly gets from the pool
    // and puts, with syncs and unused-mode noise mixed in.
    for (int phase = 0; phase < 3; phase++) begin
      zone_write(ZONE_W'($urandom_range(0, 65535)));
      counted = 0;
      while (counted < 50) begin
        pick  = $urandom_range(0, 99);
        num   = NUM_W'($urandom_range(0, 65535));
        slot  = SLOT_W'($urandom_range(0, 15));
        links = LINK_W'($urandom_range(0, 255));
        if (pick < 50) begin
          mode = MODE_GET;
          if ($urandom_range(0, 9) < 7) num = num_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 85) begin
          mode = MODE_PUT;
          if ($urandom_range(0, 3) == 0) links = '0;
        end else if (pick < 95) begin
          mode = MODE_SYNC;
        end else begin
          mode = MODE_UNUSED;
        end
        // Run the tail of the last phase with no idling on either side.
        if (phase == 2 && counted >= 25) calm = 1'b1;
        offer(mode, num, slot, links);
        if (mode != MODE_UNUSED) counted++;
      end
      quiesce();
    end

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
